### rtl/sat_pkg.sv
// Shared types and constants for the summed-area table engine.
package sat_pkg;

  localparam int DATA_W      = 64;
  localparam int COORD_W     = 7;
  localparam int KIND_W      = 3;
  localparam int COUNT_W     = 7;
  localparam int CFG_INDEX_W = 4;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_POINT_ADD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RECT_ADD  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POINT_SET = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POINT_READ = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RECT_SUM  = 3'd4;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COL_COUNT = 4'd1;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [COORD_W-1:0]        row_a;
    logic [COORD_W-1:0]        col_a;
    logic [COORD_W-1:0]        row_b;
    logic [COORD_W-1:0]        col_b;
    logic signed [DATA_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  sum;
    logic                      bad_coordinate;
  } result_t;

endpackage

### rtl/sat_grid_mem.sv
// Grid store: one write port, two registered read ports.
module sat_grid_mem #(
  parameter int DEPTH = 4356,
  parameter int AW    = 13
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [sat_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]              raddr0,
  input  logic [AW-1:0]              raddr1,
  output logic [sat_pkg::DATA_W-1:0] rdata0,
  output logic [sat_pkg::DATA_W-1:0] rdata1
);

  logic [sat_pkg::DATA_W-1:0] mem [DEPTH];

  // Read returns old data on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

### rtl/sat_integrator.sv
// In-place 2-D prefix sum sweep over the grid store, one cell per cycle.
module sat_integrator #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64,
  localparam int RW      = $clog2(MAX_ROWS + 2),
  localparam int CW      = $clog2(MAX_COLS + 2),
  localparam int CELLS   = (MAX_ROWS + 2) * (MAX_COLS + 2),
  localparam int AW      = $clog2(CELLS),
  localparam int STRIDE  = MAX_COLS + 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [RW-1:0]              h,
  input  logic [CW-1:0]              w,
  output logic [AW-1:0]              raddr0,
  output logic [AW-1:0]              raddr1,
  input  logic [sat_pkg::DATA_W-1:0] rdata0,
  input  logic [sat_pkg::DATA_W-1:0] rdata1,
  output logic                       we,
  output logic [AW-1:0]              waddr,
  output logic [sat_pkg::DATA_W-1:0] wdata,
  output logic                       done
);

  // Issue stage
  logic          active;
  logic [RW-1:0] row_i;
  logic [CW-1:0] col_j;
  logic [AW-1:0] cur;
  logic          last_cell;
  logic          row_end;

  // Update stage
  logic          p_valid;
  logic          p_last;
  logic          p_first;
  logic [AW-1:0] p_addr;
  logic [AW-1:0] p_up;

  // Last write, for the one-column case where the cell above was just written
  logic                       f_valid;
  logic [AW-1:0]              f_addr;
  logic [sat_pkg::DATA_W-1:0] f_data;

  logic [sat_pkg::DATA_W-1:0] run;
  logic [sat_pkg::DATA_W-1:0] run_next;
  logic [sat_pkg::DATA_W-1:0] up_val;

  assign row_end   = (col_j == w + CW'(1));
  assign last_cell = row_end && (row_i == h + RW'(1));

  // Current cell and the one above it
  assign raddr0 = cur;
  assign raddr1 = cur - AW'(STRIDE);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (go) begin
      active <= 1'b1;
    end else if (active && last_cell) begin
      active <= 1'b0;
    end
  end

  // Row-major walk over rows 1..h+1, columns 1..w+1
  always_ff @(posedge clk) begin
    if (go) begin
      row_i <= RW'(1);
      col_j <= CW'(1);
      cur   <= AW'(STRIDE + 1);
    end else if (active && !last_cell) begin
      if (row_end) begin
        row_i <= row_i + RW'(1);
        col_j <= CW'(1);
        cur   <= cur + AW'(STRIDE) - AW'(w);
      end else begin
        col_j <= col_j + CW'(1);
        cur   <= cur + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      f_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      p_valid <= active;
      f_valid <= p_valid;
      done    <= p_valid && p_last;
    end
  end

  always_ff @(posedge clk) begin
    p_last  <= last_cell;
    p_first <= (col_j == CW'(1));
    p_addr  <= cur;
    p_up    <= raddr1;
    f_addr  <= p_addr;
    f_data  <= wdata;
    if (p_valid) begin
      run <= run_next;
    end
  end

  // S(i,j) = S(i-1,j) + row running sum of raw cells
  assign up_val   = (f_valid && (f_addr == p_up)) ? f_data : rdata1;
  assign run_next = (p_first ? '0 : run) + rdata0;
  assign wdata    = up_val + run_next;
  assign we       = p_valid;
  assign waddr    = p_addr;

endmodule

### rtl/summed_area_table_engine_top.sv
// Summed-area table engine: command decode, sequencing and grid store.
//
//  channel  | signals                                  | beat taken when
//  ---------+------------------------------------------+-----------------------
//  command  | start, busy, cmd                         | start & !busy
//  result   | done, result                             | done (one cycle)
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data| cfg_valid & cfg_ready
//
// Point set writes the cell, point add reads and rewrites it, rectangle add
// does so at each of four corners. A read that follows an update or a clear
// first integrates the grid, one cell per cycle through the store's single
// write port.
// After reset and after every write to the row or column count a clearing
// pass writes zero to all (MAX_ROWS+2)*(MAX_COLS+2) cells; busy stays high
// meanwhile. The result side cannot stall; one item at a time.
module summed_area_table_engine_top #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  sat_pkg::cmd_t                   cmd,
  output logic                            done,
  output sat_pkg::result_t                result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sat_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sat_pkg::COUNT_W-1:0]     cfg_data
);

  localparam int RW     = $clog2(MAX_ROWS + 2);
  localparam int CW     = $clog2(MAX_COLS + 2);
  localparam int CELLS  = (MAX_ROWS + 2) * (MAX_COLS + 2);
  localparam int AW     = $clog2(CELLS);
  localparam int STRIDE = MAX_COLS + 2;
  localparam int RCW    = ((RW > sat_pkg::COORD_W) ? RW : sat_pkg::COORD_W) + 1;
  localparam int CCW    = ((CW > sat_pkg::COORD_W) ? CW : sat_pkg::COORD_W) + 1;
  localparam int DW     = sat_pkg::DATA_W;

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_INTEG     = 4'd2;
  localparam logic [3:0] S_RMW_RD    = 4'd3;
  localparam logic [3:0] S_RMW_WR    = 4'd4;
  localparam logic [3:0] S_PREAD_RD  = 4'd5;
  localparam logic [3:0] S_PREAD_OUT = 4'd6;
  localparam logic [3:0] S_RSUM_A    = 4'd7;
  localparam logic [3:0] S_RSUM_B    = 4'd8;
  localparam logic [3:0] S_RSUM_C    = 4'd9;
  localparam logic [3:0] S_RSUM_D    = 4'd10;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                              input logic [CW-1:0] c);
    cell_addr = AW'(r) * AW'(STRIDE) + AW'(c);
  endfunction

  logic [3:0]                  state;
  logic [AW-1:0]               clr_addr;
  logic                        integrated;
  logic [sat_pkg::COUNT_W-1:0] row_count;
  logic [sat_pkg::COUNT_W-1:0] col_count;

  // Latched command
  logic [sat_pkg::KIND_W-1:0]  op_kind;
  logic [AW-1:0]               addr_ll;
  logic [AW-1:0]               addr_hl;
  logic [AW-1:0]               addr_lh;
  logic [AW-1:0]               addr_hh;
  logic [DW-1:0]               amount;
  logic [DW-1:0]               amount_neg;
  logic [1:0]                  corner;
  logic [DW-1:0]               acc;
  logic [DW-1:0]               diff;

  // Decode of the incoming beat
  logic           accept;
  logic           cfg_hit;
  logic [RCW-1:0] h_x;
  logic [CCW-1:0] w_x;
  logic [RCW-1:0] ra_x;
  logic [RCW-1:0] rb_x;
  logic [CCW-1:0] ca_x;
  logic [CCW-1:0] cb_x;
  logic           point_bad;
  logic           rect_bad;
  logic           sum_bad;
  logic           cell_off;
  logic [RCW-1:0] row_lo_x;
  logic [RCW-1:0] row_hi_x;
  logic [CCW-1:0] col_lo_x;
  logic [CCW-1:0] col_hi_x;

  // Store ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr0;
  logic [AW-1:0] mem_raddr1;
  logic [DW-1:0] mem_rdata0;
  logic [DW-1:0] mem_rdata1;

  // Integrator ports
  logic          integ_go;
  logic          integ_done;
  logic          integ_we;
  logic [AW-1:0] integ_waddr;
  logic [DW-1:0] integ_wdata;
  logic [AW-1:0] integ_raddr0;
  logic [AW-1:0] integ_raddr1;

  logic [AW-1:0] corner_addr;
  logic          corner_neg;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid &&
                     ((cfg_index == sat_pkg::CFG_ROW_COUNT) ||
                      (cfg_index == sat_pkg::CFG_COL_COUNT));
  assign busy      = (state != S_IDLE) || cfg_valid;
  assign accept    = start && !busy;

  // Effective grid size and bounds checks
  assign h_x = (RCW'(row_count) > RCW'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(row_count);
  assign w_x = (CCW'(col_count) > CCW'(MAX_COLS)) ? CCW'(MAX_COLS) : CCW'(col_count);
  assign ra_x = RCW'(cmd.row_a);
  assign rb_x = RCW'(cmd.row_b);
  assign ca_x = CCW'(cmd.col_a);
  assign cb_x = CCW'(cmd.col_b);

  assign point_bad = (ra_x > h_x) || (ca_x > w_x);
  assign rect_bad  = point_bad || (rb_x > h_x) || (cb_x > w_x);
  assign sum_bad   = (ra_x > h_x + RCW'(1)) || (rb_x > h_x + RCW'(1)) ||
                     (ca_x > w_x + CCW'(1)) || (cb_x > w_x + CCW'(1));

  // Updates and point reads address the padded cell (r+1, c+1); rectangle sums address prefix cells directly
  assign cell_off = (cmd.kind != sat_pkg::KIND_RECT_SUM);
  assign row_lo_x = ra_x + RCW'(cell_off);
  assign row_hi_x = rb_x + RCW'(cell_off);
  assign col_lo_x = ca_x + CCW'(cell_off);
  assign col_hi_x = cb_x + CCW'(cell_off);

  // Start integration for a valid read on a grid touched since the last one
  always_comb begin
    integ_go = 1'b0;
    if (accept && !integrated) begin
      if (cmd.kind == sat_pkg::KIND_POINT_READ) begin
        integ_go = !point_bad;
      end else if (cmd.kind == sat_pkg::KIND_RECT_SUM) begin
        integ_go = !sum_bad;
      end
    end
  end

  // Capture the command payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind    <= cmd.kind;
      addr_ll    <= cell_addr(row_lo_x[RW-1:0], col_lo_x[CW-1:0]);
      addr_hl    <= cell_addr(row_hi_x[RW-1:0], col_lo_x[CW-1:0]);
      addr_lh    <= cell_addr(row_lo_x[RW-1:0], col_hi_x[CW-1:0]);
      addr_hh    <= cell_addr(row_hi_x[RW-1:0], col_hi_x[CW-1:0]);
      amount     <= cmd.value;
      amount_neg <= DW'(0) - cmd.value;
    end
  end

  // Corner order for a rectangle add: +ll, -hl, -lh, +hh
  always_comb begin
    case (corner)
      2'd0:    corner_addr = addr_ll;
      2'd1:    corner_addr = addr_hl;
      2'd2:    corner_addr = addr_lh;
      default: corner_addr = addr_hh;
    endcase
  end
  assign corner_neg = (corner == 2'd1) || (corner == 2'd2);

  // Main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      integrated <= 1'b0;
      row_count  <= sat_pkg::COUNT_RESET;
      col_count  <= sat_pkg::COUNT_RESET;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_hit) begin
        // Resize: clear the grid again
        if (cfg_index == sat_pkg::CFG_ROW_COUNT) begin
          row_count <= cfg_data;
        end else begin
          col_count <= cfg_data;
        end
        state      <= S_CLEAR;
        clr_addr   <= '0;
        integrated <= 1'b0;
      end else begin
        unique case (state)
          S_CLEAR: begin
            if (clr_addr == AW'(CELLS - 1)) begin
              state <= S_IDLE;
            end else begin
              clr_addr <= clr_addr + AW'(1);
            end
          end
          S_IDLE: begin
            if (accept) begin
              corner <= 2'd0;
              unique case (cmd.kind) inside
                sat_pkg::KIND_POINT_ADD, sat_pkg::KIND_POINT_SET,
                sat_pkg::KIND_POINT_READ: begin
                  if (point_bad) begin
                    result.sum            <= '0;
                    result.bad_coordinate <= 1'b1;
                    done                  <= 1'b1;
                  end else if (cmd.kind == sat_pkg::KIND_POINT_SET) begin
                    integrated <= 1'b0;
                    state      <= S_RMW_WR;
                  end else if (cmd.kind == sat_pkg::KIND_POINT_ADD) begin
                    integrated <= 1'b0;
                    state      <= S_RMW_RD;
                  end else begin
                    state <= integrated ? S_PREAD_RD : S_INTEG;
                  end
                end
                sat_pkg::KIND_RECT_ADD: begin
                  if (rect_bad) begin
                    result.sum            <= '0;
                    result.bad_coordinate <= 1'b1;
                    done                  <= 1'b1;
                  end else begin
                    integrated <= 1'b0;
                    state      <= S_RMW_RD;
                  end
                end
                sat_pkg::KIND_RECT_SUM: begin
                  if (sum_bad) begin
                    result.sum            <= '0;
                    result.bad_coordinate <= 1'b1;
                    done                  <= 1'b1;
                  end else begin
                    state <= integrated ? S_RSUM_A : S_INTEG;
                  end
                end
                default: begin
                  result.sum            <= '0;
                  result.bad_coordinate <= 1'b0;
                  done                  <= 1'b1;
                end
              endcase
            end
          end
          S_INTEG: begin
            if (integ_done) begin
              integrated <= 1'b1;
              state <= (op_kind == sat_pkg::KIND_RECT_SUM) ? S_RSUM_A : S_PREAD_RD;
            end
          end
          S_RMW_RD: begin
            state <= S_RMW_WR;
          end
          S_RMW_WR: begin
            if (op_kind == sat_pkg::KIND_RECT_ADD && corner != 2'd3) begin
              corner <= corner + 2'd1;
              state  <= S_RMW_RD;
            end else begin
              result.sum            <= '0;
              result.bad_coordinate <= 1'b0;
              done                  <= 1'b1;
              state                 <= S_IDLE;
            end
          end
          S_PREAD_RD: begin
            state <= S_PREAD_OUT;
          end
          S_PREAD_OUT: begin
            result.sum            <= mem_rdata0;
            result.bad_coordinate <= 1'b0;
            done                  <= 1'b1;
            state                 <= S_IDLE;
          end
          S_RSUM_A: begin
            state <= S_RSUM_B;
          end
          S_RSUM_B: begin
            // S(rb,cb) - S(ra,cb)
            acc   <= mem_rdata0 - mem_rdata1;
            state <= S_RSUM_C;
          end
          S_RSUM_C: begin
            // S(ra,ca) - S(rb,ca)
            diff  <= mem_rdata1 - mem_rdata0;
            state <= S_RSUM_D;
          end
          S_RSUM_D: begin
            result.sum            <= acc + diff;
            result.bad_coordinate <= 1'b0;
            done                  <= 1'b1;
            state                 <= S_IDLE;
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

  // Store port selection
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = corner_addr;
    mem_wdata  = '0;
    mem_raddr0 = corner_addr;
    mem_raddr1 = addr_ll;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      S_INTEG: begin
        mem_we     = integ_we;
        mem_waddr  = integ_waddr;
        mem_wdata  = integ_wdata;
        mem_raddr0 = integ_raddr0;
        mem_raddr1 = integ_raddr1;
      end
      S_RMW_WR: begin
        mem_we = 1'b1;
        if (op_kind == sat_pkg::KIND_POINT_SET) begin
          mem_wdata = amount;
        end else begin
          mem_wdata = mem_rdata0 + (corner_neg ? amount_neg : amount);
        end
      end
      S_PREAD_RD: begin
        mem_raddr0 = addr_ll;
      end
      S_RSUM_A: begin
        mem_raddr0 = addr_hh;
        mem_raddr1 = addr_lh;
      end
      S_RSUM_B: begin
        mem_raddr0 = addr_hl;
        mem_raddr1 = addr_ll;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  sat_integrator #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_integrator (
    .clk    (clk),
    .rst    (rst),
    .go     (integ_go),
    .h      (h_x[RW-1:0]),
    .w      (w_x[CW-1:0]),
    .raddr0 (integ_raddr0),
    .raddr1 (integ_raddr1),
    .rdata0 (mem_rdata0),
    .rdata1 (mem_rdata1),
    .we     (integ_we),
    .waddr  (integ_waddr),
    .wdata  (integ_wdata),
    .done   (integ_done)
  );

  sat_grid_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_grid (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .raddr0 (mem_raddr0),
    .raddr1 (mem_raddr1),
    .rdata0 (mem_rdata0),
    .rdata1 (mem_rdata1)
  );

endmodule
